>>> design/oesu_pkg.sv
`timescale 1ns / 1ps
package oesu_pkg;
  localparam int unsigned PointsDef = 1024;
  localparam int unsigned NumComp   = 6;
  localparam int unsigned NumStiff  = 36;

  localparam logic [2:0] ActUpdate = 3'd0;
  localparam logic [2:0] ActStiff  = 3'd1;
  localparam logic [2:0] ActStress = 3'd2;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [9:0]  entry_index;
    word_t       value;
    word_t [5:0] strain;
    word_t [2:0] spin;
  } req_t;

  typedef struct packed {
    logic [9:0]  point_number;
    word_t [5:0] stress;
    logic        saturated;
    logic        bad_step;
  } rsp_t;

  function automatic logic signed [63:0] mulq(input word_t a, input word_t b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b);
      return p >>> 14;
    end
  endfunction
endpackage

>>> design/oesu_if.sv
`timescale 1ns / 1ps
interface oesu_req_if;
  logic          valid;
  logic          ready;
  oesu_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/oesu_rsp_if.sv
`timescale 1ns / 1ps
interface oesu_rsp_if;
  logic          valid;
  logic          ready;
  oesu_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/oesu_cfg_if.sv
`timescale 1ns / 1ps
interface oesu_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/objective_elastic_stress_update.sv
`timescale 1ns / 1ps
// update: reads the old stress, pushes 6 rows through the calculator and writes back
// the 6 new components; the response is valid after the write-back
// one point at a time; stress and stiffness writes complete in the cycle they are taken
// the stress memory has one read port and one write port; components are read and written back one a cycle
// reset clears the stiffness table and sets time_step to one;
// the stress memory is not cleared
module objective_elastic_stress_update #(
  parameter int unsigned Points = oesu_pkg::PointsDef
) (
  input logic clk_i,
  input logic rst_ni,
  oesu_req_if.sink   req,
  oesu_rsp_if.source rsp,
  oesu_cfg_if.sink   cfg
);
  localparam int unsigned Depth = Points * oesu_pkg::NumComp;
  localparam int unsigned AW = $clog2(Depth);

  typedef enum logic [4:0] {
    StIdle = 5'b00001, StRead = 5'b00010, StCalc = 5'b00100,
    StWrite = 5'b01000, StOut = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] step_q;
  // one entry per stress row, one word per strain column
  oesu_pkg::word_t [5:0] stiff_q [oesu_pkg::NumComp];
  oesu_pkg::req_t  cur_q;
  oesu_pkg::word_t [5:0] s_q, res_q;
  logic [2:0] cnt_q;
  logic sat_q, calc_v_q;
  logic [2:0] calc_row_q;

  logic we;
  logic [AW-1:0] waddr, raddr, base;
  oesu_pkg::word_t wdata, rdata, cres;
  oesu_pkg::word_t [5:0] krow;
  logic csat, acc, in_rng;
  logic [2:0] st_col, st_row;

  oesu_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign req.ready = (state_q == StIdle);
  assign cfg.ready = 1'b1;
  assign acc = req.valid && req.ready;
  assign in_rng = 32'(req.data.entry_index) < Points;
  assign base = AW'(32'(cur_q.entry_index) * oesu_pkg::NumComp);

  assign krow = stiff_q[cnt_q];

  // split a stiffness entry into strain column and stress row
  always_comb begin
    st_col = 3'd0;
    for (int j = 1; j < 6; j++) begin
      if (req.data.entry_index >= 10'(6 * j)) st_col = 3'(j);
    end
    st_row = 3'(req.data.entry_index[5:0] - 6'd6 * 6'(st_col));
  end

  oesu_calc u_calc (
    .clk_i, .row_i(cnt_q), .s_i(s_q), .w_i(cur_q.spin), .e_i(cur_q.strain),
    .k_i(krow), .res_o(cres), .sat_o(csat)
  );

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = base + AW'(cnt_q);
    if (acc && req.data.action >= oesu_pkg::ActStress && in_rng) begin
      we = 1'b1;
      waddr = AW'(32'(req.data.entry_index) * oesu_pkg::NumComp
                  + 32'(req.data.action - oesu_pkg::ActStress));
      wdata = req.data.value;
    end else if (state_q == StWrite) begin
      we = 1'b1; waddr = base + AW'(cnt_q); wdata = res_q[cnt_q];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (acc && req.data.action == oesu_pkg::ActUpdate && in_rng) state_d = StRead;
      StRead:  if (cnt_q == 3'd6) state_d = StCalc;
      StCalc:  if (calc_v_q && calc_row_q == 3'd5) state_d = StWrite;
      StWrite: if (cnt_q == 3'd5) state_d = StOut;
      StOut:   if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; step_q <= 32'd1; cnt_q <= '0; calc_v_q <= 1'b0;
      calc_row_q <= '0; sat_q <= 1'b0;
      for (int k = 0; k < oesu_pkg::NumComp; k++) stiff_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid) step_q <= cfg.data;
      if (acc && req.data.action == oesu_pkg::ActStiff
          && 32'(req.data.entry_index) < oesu_pkg::NumStiff)
        stiff_q[st_row][st_col] <= req.data.value;
      calc_v_q <= 1'b0;
      case (state_q)
        StIdle: begin cnt_q <= '0; sat_q <= 1'b0; end
        StRead: begin
          // read data arrives in the cycle after its address
          if (cnt_q != 3'd0) s_q[cnt_q - 3'd1] <= rdata;
          cnt_q <= (cnt_q == 3'd6) ? 3'd0 : cnt_q + 3'd1;
        end
        StCalc: begin
          if (cnt_q != 3'd6) begin
            calc_v_q <= 1'b1; calc_row_q <= cnt_q; cnt_q <= cnt_q + 3'd1;
          end
          if (calc_v_q) begin
            res_q[calc_row_q] <= cres;
            sat_q <= sat_q | csat;
          end
          if (calc_v_q && calc_row_q == 3'd5) cnt_q <= '0;
        end
        StWrite: cnt_q <= cnt_q + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) cur_q <= req.data;
  end

  assign rsp.valid = (state_q == StOut);
  assign rsp.data.point_number = cur_q.entry_index;
  assign rsp.data.stress = res_q;
  assign rsp.data.saturated = sat_q;
  assign rsp.data.bad_step = (step_q == 32'd0);
endmodule

>>> design/oesu_ram.sv
`timescale 1ns / 1ps
module oesu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/oesu_calc.sv
`timescale 1ns / 1ps
// one stress row per pass: rotation, old stress and six stiffness products
module oesu_calc (
  input  logic                  clk_i,
  input  logic [2:0]            row_i,
  input  oesu_pkg::word_t [5:0] s_i,
  input  oesu_pkg::word_t [2:0] w_i,
  input  oesu_pkg::word_t [5:0] e_i,
  input  oesu_pkg::word_t [5:0] k_i,
  output oesu_pkg::word_t       res_o,
  output logic                  sat_o
);
  logic signed [63:0] rot_d, rot_q, base_q, stf_d, stf_q, sum;
  logic signed [63:0] r;
  logic signed [63:0] p [5:0];

  always_comb begin
    case (row_i)
      3'd0: rot_d = 64'(2) * (oesu_pkg::mulq(s_i[3], w_i[0]) + oesu_pkg::mulq(s_i[5], w_i[2]));
      3'd1: rot_d = -64'(2) * (oesu_pkg::mulq(s_i[3], w_i[0]) - oesu_pkg::mulq(s_i[4], w_i[1]));
      3'd2: rot_d = -64'(2) * (oesu_pkg::mulq(s_i[5], w_i[2]) + oesu_pkg::mulq(s_i[4], w_i[1]));
      3'd3: rot_d = oesu_pkg::mulq(s_i[1], w_i[0]) - oesu_pkg::mulq(s_i[0], w_i[0])
                  + oesu_pkg::mulq(s_i[4], w_i[2]) + oesu_pkg::mulq(s_i[5], w_i[1]);
      3'd4: rot_d = oesu_pkg::mulq(s_i[2], w_i[1]) - oesu_pkg::mulq(s_i[1], w_i[1])
                  - oesu_pkg::mulq(s_i[3], w_i[2]) - oesu_pkg::mulq(s_i[5], w_i[0]);
      3'd5: rot_d = oesu_pkg::mulq(s_i[2], w_i[2]) - oesu_pkg::mulq(s_i[0], w_i[2])
                  + oesu_pkg::mulq(s_i[4], w_i[0]) - oesu_pkg::mulq(s_i[3], w_i[1]);
      default: rot_d = '0;
    endcase
    for (int j = 0; j < 6; j++) p[j] = oesu_pkg::mulq(k_i[j], e_i[j]);
    stf_d = p[0] + p[1] + p[2] + p[3] + p[4] + p[5];
  end

  always_ff @(posedge clk_i) begin
    rot_q  <= rot_d;
    stf_q  <= stf_d;
    base_q <= 64'(s_i[row_i]) <<< 16;
  end

  always_comb begin
    sum = rot_q + stf_q + base_q + 64'sd32768;
    r   = sum >>> 16;
    sat_o = 1'b0;
    if (r > 64'sd2147483647) begin
      res_o = 32'h7fffffff; sat_o = 1'b1;
    end else if (r < -64'sd2147483648) begin
      res_o = 32'h80000000; sat_o = 1'b1;
    end else begin
      res_o = r[31:0];
    end
  end
endmodule
